/* hw/rtl/rv64im_integer_alu_core_assert.svh */
// Assertion macros for the RV64IM integer ALU core.
// Used by the top level only; needs a signal named clock and one named reset.
`ifndef RV64IM_INTEGER_ALU_CORE_ASSERT_SVH
`define RV64IM_INTEGER_ALU_CORE_ASSERT_SVH

// same-cycle implication
`define RVALU_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RVALU_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/rvalu_pkg.sv */
// Package for the RV64IM integer ALU core: operation and status codes, types.
// No dependencies.
`default_nettype none
package rvalu_pkg;
   localparam int XLEN = 64;

   typedef logic [4:0] cmd_type;
   typedef logic [1:0] status_type;

   localparam cmd_type CMD_ADD    = 5'd0;
   localparam cmd_type CMD_SUB    = 5'd1;
   localparam cmd_type CMD_SLL    = 5'd2;
   localparam cmd_type CMD_SLT    = 5'd3;
   localparam cmd_type CMD_SLTU   = 5'd4;
   localparam cmd_type CMD_XOR    = 5'd5;
   localparam cmd_type CMD_SRL    = 5'd6;
   localparam cmd_type CMD_SRA    = 5'd7;
   localparam cmd_type CMD_OR     = 5'd8;
   localparam cmd_type CMD_AND    = 5'd9;
   localparam cmd_type CMD_MUL    = 5'd10;
   localparam cmd_type CMD_MULH   = 5'd11;
   localparam cmd_type CMD_MULHSU = 5'd12;
   localparam cmd_type CMD_MULHU  = 5'd13;
   localparam cmd_type CMD_DIV    = 5'd14;
   localparam cmd_type CMD_DIVU   = 5'd15;
   localparam cmd_type CMD_REM    = 5'd16;
   localparam cmd_type CMD_REMU   = 5'd17;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_DIVZ  = 2'd1;
   localparam status_type ST_UNSUP = 2'd2;

   typedef enum logic [1:0] {
      KIND_ALU = 2'd0,
      KIND_MUL = 2'd1,
      KIND_DIV = 2'd2
   } kind_type;

   typedef struct packed {
      status_type status;
      kind_type   kind;
      logic       word;
      logic       neg_q;
      logic       neg_r;
      logic       is_rem;
      logic       mul_hi;
      logic       fix_a;
      logic       fix_b;
   } meta_type;

   function automatic logic [XLEN-1:0] sext32(input logic [XLEN-1:0] v);
      return {{32{v[31]}}, v[31:0]};
   endfunction
endpackage
`default_nettype wire

/* hw/rtl/rvalu_if.sv */
// Valid/ready channel interfaces for the RV64IM integer ALU core.
// Depends on rvalu_pkg.
`default_nettype none
interface rvalu_req_if
   import rvalu_pkg::*;
();
   logic              valid;
   logic              ready;
   cmd_type           cmd;
   logic              word_mode;
   logic [XLEN-1:0]   src_a;
   logic [XLEN-1:0]   src_b;
   modport source (output valid, cmd, word_mode, src_a, src_b, input ready);
   modport sink   (input valid, cmd, word_mode, src_a, src_b, output ready);
endinterface

interface rvalu_rsp_if
   import rvalu_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [XLEN-1:0]   result;
   status_type        status;
   modport source (output valid, result, status, input ready);
   modport sink   (input valid, result, status, output ready);
endinterface
`default_nettype wire

/* hw/rtl/rv64im_integer_alu_core.sv */
// RV64IM integer ALU core: pipelined add/shift/logic, multiplier and divider.
// Depends on rvalu_pkg, rvalu_if.sv and rv64im_integer_alu_core_assert.svh.
`default_nettype none
`include "rv64im_integer_alu_core_assert.svh"
// Usage
//  req_ch (sink): one beat carries cmd, word_mode, src_a and src_b.
//  rsp_ch (source): one beat per request, result and status, in request order.
//  Throughput: one beat per cycle while the output does not stall, for every operation mix.
//  The depth is set by the divider: a restoring array of 64 stages, one
//   quotient bit per stage. Stage 0 registers the request and the operand
//   magnitudes, stages 1..64 hold the divider steps; the ALU result is made
//   in stage 1 and the multiplier (four 32x32 partial products, sum,
//   sign correction) in stages 1..3, and both ride along to the end.
//  Stage 65 is the output register: sign fix-up, word sign extension and
//   forcing of result to zero on a bad status.
//  Stall: the whole pipe holds while the output beat waits; req_ch.ready
//   is low only then and during reset, so nothing is lost or repeated.
//  Reset clears the stage valid bits only; payload registers are not reset.
module rv64im_integer_alu_core
   import rvalu_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   rvalu_req_if.sink   req_ch,
   rvalu_rsp_if.source rsp_ch
);
   localparam int DIV_STEPS = XLEN;
   localparam int LAST      = DIV_STEPS;

   logic enable;

   // stage 0 registers
   logic              v_ff [0:LAST];
   cmd_type           s0_cmd_ff;
   logic              s0_word_ff;
   logic [XLEN-1:0]   s0_a_ff, s0_b_ff;
   logic              s0_neg_a_ff, s0_neg_b_ff;

   // divider array
   logic [XLEN-1:0]   dv_rem_ff [0:DIV_STEPS];
   logic [XLEN-1:0]   dv_q_ff   [0:DIV_STEPS];
   logic [XLEN-1:0]   dv_d_ff   [0:DIV_STEPS];

   // carried payload
   meta_type          meta_ff [1:LAST];
   logic [XLEN-1:0]   res_ff  [1:LAST];

   // multiplier stages
   logic [XLEN-1:0]   pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff;
   logic [2*XLEN-1:0] prod_ff;
   logic [XLEN-1:0]   ma_ff [1:2];
   logic [XLEN-1:0]   mb_ff [1:2];

   // output register
   logic              rsp_valid_ff;
   logic [XLEN-1:0]   rsp_result_ff;
   status_type        rsp_status_ff;

   assign enable       = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = enable && !reset;
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.result = rsp_result_ff;
   assign rsp_ch.status = rsp_status_ff;

   // ---------------- stage 0: operand preparation ----------------
   logic            in_sdiv;
   logic [XLEN-1:0] op_a_in, op_b_in, dvd_in, dvs_in;
   logic            neg_a_in, neg_b_in;

   always_comb begin
      in_sdiv = (req_ch.cmd == CMD_DIV) || (req_ch.cmd == CMD_REM);
      if (req_ch.word_mode) begin
         op_a_in = in_sdiv ? sext32(req_ch.src_a) : {32'd0, req_ch.src_a[31:0]};
         op_b_in = in_sdiv ? sext32(req_ch.src_b) : {32'd0, req_ch.src_b[31:0]};
      end else begin
         op_a_in = req_ch.src_a;
         op_b_in = req_ch.src_b;
      end
      neg_a_in = in_sdiv && op_a_in[XLEN-1];
      neg_b_in = in_sdiv && op_b_in[XLEN-1];
      dvd_in   = neg_a_in ? (~op_a_in + XLEN'(1)) : op_a_in;
      dvs_in   = neg_b_in ? (~op_b_in + XLEN'(1)) : op_b_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAST; i++) v_ff[i] <= 1'b0;
      end else if (enable) begin
         v_ff[0] <= req_ch.valid;
         for (int i = 1; i <= LAST; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s0_cmd_ff    <= req_ch.cmd;
         s0_word_ff   <= req_ch.word_mode;
         s0_a_ff      <= req_ch.src_a;
         s0_b_ff      <= req_ch.src_b;
         s0_neg_a_ff  <= neg_a_in;
         s0_neg_b_ff  <= neg_b_in;
         dv_rem_ff[0] <= '0;
         dv_q_ff[0]   <= dvd_in;
         dv_d_ff[0]   <= dvs_in;
      end
   end

   // ---------------- stage 1: decode, ALU, partial products ----------------
   meta_type        meta_in;
   logic [XLEN-1:0] alu_in;
   logic [5:0]      shamt;
   logic            div_zero;

   always_comb begin
      shamt    = s0_word_ff ? {1'b0, s0_b_ff[4:0]} : s0_b_ff[5:0];
      div_zero = s0_word_ff ? (s0_b_ff[31:0] == 32'd0) : (s0_b_ff == '0);
      meta_in         = '0;
      meta_in.word    = s0_word_ff;
      meta_in.kind    = KIND_ALU;
      meta_in.status  = ST_OK;
      meta_in.neg_q   = s0_neg_a_ff ^ s0_neg_b_ff;
      meta_in.neg_r   = s0_neg_a_ff;
      meta_in.is_rem  = (s0_cmd_ff == CMD_REM) || (s0_cmd_ff == CMD_REMU);
      meta_in.mul_hi  = (s0_cmd_ff != CMD_MUL);
      meta_in.fix_a   = s0_a_ff[XLEN-1] &&
                        ((s0_cmd_ff == CMD_MULH) || (s0_cmd_ff == CMD_MULHSU));
      meta_in.fix_b   = s0_b_ff[XLEN-1] && (s0_cmd_ff == CMD_MULH);
      alu_in = '0;
      case (s0_cmd_ff)
         CMD_ADD:  alu_in = s0_a_ff + s0_b_ff;
         CMD_SUB:  alu_in = s0_a_ff - s0_b_ff;
         CMD_SLL:  alu_in = s0_a_ff << shamt;
         CMD_SLT:  alu_in = {63'd0, ($signed(s0_a_ff) < $signed(s0_b_ff))};
         CMD_SLTU: alu_in = {63'd0, (s0_a_ff < s0_b_ff)};
         CMD_XOR:  alu_in = s0_a_ff ^ s0_b_ff;
         CMD_SRL:  alu_in = s0_word_ff ? ({32'd0, s0_a_ff[31:0]} >> shamt)
                                       : (s0_a_ff >> shamt);
         CMD_SRA:  alu_in = s0_word_ff ? ($signed(sext32(s0_a_ff)) >>> shamt)
                                       : ($signed(s0_a_ff) >>> shamt);
         CMD_OR:   alu_in = s0_a_ff | s0_b_ff;
         CMD_AND:  alu_in = s0_a_ff & s0_b_ff;
         CMD_MUL, CMD_MULH, CMD_MULHSU, CMD_MULHU: meta_in.kind = KIND_MUL;
         CMD_DIV, CMD_DIVU, CMD_REM, CMD_REMU: begin
            meta_in.kind = KIND_DIV;
            if (div_zero) meta_in.status = ST_DIVZ;
         end
         default: meta_in.status = ST_UNSUP;
      endcase
      if (s0_word_ff) begin
         alu_in = sext32(alu_in);
         if (s0_cmd_ff inside {CMD_SLT, CMD_SLTU, CMD_XOR, CMD_OR, CMD_AND,
                               CMD_MULH, CMD_MULHSU, CMD_MULHU})
            meta_in.status = ST_UNSUP;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         meta_ff[1] <= meta_in;
         res_ff[1]  <= alu_in;
         pp_ll_ff   <= XLEN'(s0_a_ff[31:0])  * XLEN'(s0_b_ff[31:0]);
         pp_lh_ff   <= XLEN'(s0_a_ff[31:0])  * XLEN'(s0_b_ff[63:32]);
         pp_hl_ff   <= XLEN'(s0_a_ff[63:32]) * XLEN'(s0_b_ff[31:0]);
         pp_hh_ff   <= XLEN'(s0_a_ff[63:32]) * XLEN'(s0_b_ff[63:32]);
         ma_ff[1]   <= s0_a_ff;
         mb_ff[1]   <= s0_b_ff;
      end
   end

   // ---------------- stage 2: product sum ----------------
   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff  <= {pp_hh_ff, pp_ll_ff} + {32'd0, pp_lh_ff, 32'd0}
                   + {32'd0, pp_hl_ff, 32'd0};
         ma_ff[2] <= ma_ff[1];
         mb_ff[2] <= mb_ff[1];
         meta_ff[2] <= meta_ff[1];
         res_ff[2]  <= res_ff[1];
      end
   end

   // ---------------- stage 3: signed high correction, low half select ----------------
   logic [XLEN-1:0] mul_in;

   always_comb begin
      if (meta_ff[2].mul_hi)
         mul_in = prod_ff[2*XLEN-1:XLEN] - (meta_ff[2].fix_a ? mb_ff[2] : '0)
                - (meta_ff[2].fix_b ? ma_ff[2] : '0);
      else if (meta_ff[2].word)
         mul_in = sext32(prod_ff[XLEN-1:0]);
      else
         mul_in = prod_ff[XLEN-1:0];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         meta_ff[3] <= meta_ff[2];
         res_ff[3]  <= (meta_ff[2].kind == KIND_MUL) ? mul_in : res_ff[2];
      end
   end

   // stages 4..64: payload rides along beside the divider
   for (genvar g = 4; g <= LAST; g++) begin : g_carry
      always_ff @(posedge clock) begin
         if (enable) begin
            meta_ff[g] <= meta_ff[g-1];
            res_ff[g]  <= res_ff[g-1];
         end
      end
   end

   // ---------------- stages 1..64: restoring divider ----------------
   for (genvar g = 1; g <= DIV_STEPS; g++) begin : g_div
      logic [XLEN:0]   shifted;
      logic [XLEN+1:0] diff;
      logic            take;
      assign shifted = {dv_rem_ff[g-1], dv_q_ff[g-1][XLEN-1]};
      assign diff    = {1'b0, shifted} - {2'b00, dv_d_ff[g-1]};
      assign take    = !diff[XLEN+1];
      always_ff @(posedge clock) begin
         if (enable) begin
            dv_rem_ff[g] <= take ? diff[XLEN-1:0] : shifted[XLEN-1:0];
            dv_q_ff[g]   <= {dv_q_ff[g-1][XLEN-2:0], take};
            dv_d_ff[g]   <= dv_d_ff[g-1];
         end
      end
   end

   // ---------------- output stage ----------------
   logic [XLEN-1:0] div_raw, div_res, out_res;
   meta_type        fm;

   always_comb begin
      fm = meta_ff[LAST];
      if (fm.is_rem)
         div_raw = fm.neg_r ? (~dv_rem_ff[DIV_STEPS] + XLEN'(1)) : dv_rem_ff[DIV_STEPS];
      else
         div_raw = fm.neg_q ? (~dv_q_ff[DIV_STEPS] + XLEN'(1)) : dv_q_ff[DIV_STEPS];
      div_res = fm.word ? sext32(div_raw) : div_raw;
      out_res = (fm.kind == KIND_DIV) ? div_res : res_ff[LAST];
      if (fm.status != ST_OK) out_res = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= v_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_result_ff <= out_res;
         rsp_status_ff <= fm.status;
      end
   end

   // ---------------- checks ----------------
   `RVALU_ASSERT_IMP(a_bad_status_zero, rsp_valid_ff && (rsp_status_ff != ST_OK),
      rsp_result_ff == '0, "result not zero on error status")
   `RVALU_ASSERT_NXT(a_last_to_out, enable && v_ff[LAST],
      rsp_valid_ff, "beat lost between last stage and output")
   `RVALU_ASSERT_IMP(a_stall_reaches_input, rsp_valid_ff && !rsp_ch.ready,
      !req_ch.ready, "request taken during output stall")
endmodule
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for rv64im_integer_alu_core: directed table, then random beats.
// Depends on rvalu_pkg and the rvalu_req_if / rvalu_rsp_if interfaces.
`default_nettype none
module testbench;
   import rvalu_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam cmd_type CMD_UNKNOWN = 5'd31;
   localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
   localparam logic [63:0] ONES64 = '1;
   localparam int N_RANDOM = 1430;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;

   typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} phase_type;

   typedef struct packed {
      logic [63:0] result;
      status_type  status;
   } outcome_type;

   typedef struct {
      cmd_type     cmd;
      logic        word;
      logic [63:0] a;
      logic [63:0] b;
      logic        typed;  // expected value written in the row
      outcome_type want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #6 clock = ~clock;

   rvalu_req_if req_ch ();
   rvalu_rsp_if rsp_ch ();

   rv64im_integer_alu_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   outcome_type pending_results[$];
   int          n_errors = 0;
   int          n_sent = 0;
   phase_type   phase = PH_FREE;
   int          cycles = 0;

   // ---------------------------------------------------------------- predictor
   function automatic outcome_type alu_outcome(cmd_type cmd, logic word,
                                               logic [63:0] a, logic [63:0] b);
      outcome_type        o;
      logic signed [127:0] pa, pb, prod;
      logic signed [63:0]  sa, sb;
      logic [31:0]         a32, b32, r32;
      logic signed [31:0]  sa32, sb32;
      o.result = '0;
      o.status = ST_OK;
      sa = a;
      sb = b;
      a32 = a[31:0];
      b32 = b[31:0];
      sa32 = a32;
      sb32 = b32;
      if (!word) begin
         case (cmd)
            CMD_ADD:  o.result = a + b;
            CMD_SUB:  o.result = a - b;
            CMD_SLL:  o.result = a << b[5:0];
            CMD_SLT:  o.result = {63'd0, sa < sb};
            CMD_SLTU: o.result = {63'd0, a < b};
            CMD_XOR:  o.result = a ^ b;
            CMD_SRL:  o.result = a >> b[5:0];
            CMD_SRA:  o.result = sa >>> b[5:0];
            CMD_OR:   o.result = a | b;
            CMD_AND:  o.result = a & b;
            CMD_MUL:  o.result = a * b;
            CMD_MULH, CMD_MULHSU, CMD_MULHU: begin
               pa = (cmd == CMD_MULHU) ? $signed({64'd0, a}) : $signed({{64{a[63]}}, a});
               pb = (cmd == CMD_MULH) ? $signed({{64{b[63]}}, b}) : $signed({64'd0, b});
               prod = pa * pb;
               o.result = prod[127:64];
            end
            CMD_DIV, CMD_REM: begin
               if (b == '0) o.status = ST_DIVZ;
               else if (a == MIN64 && b == ONES64) o.result = (cmd == CMD_DIV) ? MIN64 : '0;
               else o.result = (cmd == CMD_DIV) ? sa / sb : sa % sb;
            end
            CMD_DIVU, CMD_REMU: begin
               if (b == '0) o.status = ST_DIVZ;
               else o.result = (cmd == CMD_DIVU) ? a / b : a % b;
            end
            default: o.status = ST_UNSUP;
         endcase
      end else begin
         r32 = '0;
         case (cmd)
            CMD_ADD: r32 = a32 + b32;
            CMD_SUB: r32 = a32 - b32;
            CMD_SLL: r32 = a32 << b[4:0];
            CMD_SRL: r32 = a32 >> b[4:0];
            CMD_SRA: r32 = sa32 >>> b[4:0];
            CMD_MUL: r32 = a32 * b32;
            CMD_DIV, CMD_REM: begin
               if (b32 == '0) o.status = ST_DIVZ;
               else if (a32 == 32'h8000_0000 && b32 == '1)
                  r32 = (cmd == CMD_DIV) ? 32'h8000_0000 : '0;
               else r32 = (cmd == CMD_DIV) ? sa32 / sb32 : sa32 % sb32;
            end
            CMD_DIVU, CMD_REMU: begin
               if (b32 == '0) o.status = ST_DIVZ;
               else r32 = (cmd == CMD_DIVU) ? a32 / b32 : a32 % b32;
            end
            default: o.status = ST_UNSUP;
         endcase
         if (o.status == ST_OK) o.result = {{32{r32[31]}}, r32};
      end
      return o;
   endfunction

   // ---------------------------------------------------------------- directed table
   // typed rows carry their own answer; the rest go through the predictor
   row_type dir_rows[] = '{
      '{CMD_ADD,    1'b0, ONES64, 64'd1,  1'b1, '{64'd0, ST_OK}},
      '{CMD_SUB,    1'b0, 64'd0,  64'd1,  1'b1, '{ONES64, ST_OK}},
      '{CMD_ADD,    1'b1, 64'h7fff_ffff, 64'd1, 1'b1, '{64'hffff_ffff_8000_0000, ST_OK}},
      '{CMD_SLL,    1'b0, 64'd1,  64'hffc0_0000_0000_003f, 1'b1, '{MIN64, ST_OK}},
      '{CMD_SLL,    1'b1, 64'd1,  64'd63, 1'b1, '{64'hffff_ffff_8000_0000, ST_OK}},
      '{CMD_SRA,    1'b0, MIN64,  64'd63, 1'b1, '{ONES64, ST_OK}},
      '{CMD_SRL,    1'b0, MIN64,  64'd63, 1'b1, '{64'd1, ST_OK}},
      '{CMD_SRA,    1'b1, 64'h8000_0000, 64'd31, 1'b0, '{64'd0, ST_OK}},
      '{CMD_SLT,    1'b0, MIN64,  64'd0,  1'b1, '{64'd1, ST_OK}},
      '{CMD_SLTU,   1'b0, MIN64,  64'd0,  1'b1, '{64'd0, ST_OK}},
      '{CMD_XOR,    1'b0, ONES64, 64'h5555_5555_5555_5555, 1'b0, '{64'd0, ST_OK}},
      '{CMD_OR,     1'b1, 64'd1,  64'd2,  1'b1, '{64'd0, ST_UNSUP}},
      '{CMD_MULH,   1'b1, ONES64, ONES64, 1'b1, '{64'd0, ST_UNSUP}},
      '{CMD_MULH,   1'b0, MIN64,  MIN64,  1'b1, '{64'h4000_0000_0000_0000, ST_OK}},
      '{CMD_MULHSU, 1'b0, ONES64, ONES64, 1'b1, '{ONES64, ST_OK}},
      '{CMD_MULHU,  1'b0, ONES64, ONES64, 1'b1, '{64'hffff_ffff_ffff_fffe, ST_OK}},
      '{CMD_MUL,    1'b1, 64'hffff_ffff, 64'h2, 1'b1, '{64'hffff_ffff_ffff_fffe, ST_OK}},
      '{CMD_DIV,    1'b0, MIN64,  ONES64, 1'b1, '{MIN64, ST_OK}},
      '{CMD_REM,    1'b0, MIN64,  ONES64, 1'b1, '{64'd0, ST_OK}},
      '{CMD_DIV,    1'b1, 64'h8000_0000, ONES64, 1'b1, '{64'hffff_ffff_8000_0000, ST_OK}},
      '{CMD_DIVU,   1'b0, 64'd5,  64'd0,  1'b1, '{64'd0, ST_DIVZ}},
      '{CMD_REMU,   1'b1, 64'd5,  64'hffff_ffff_0000_0000, 1'b1, '{64'd0, ST_DIVZ}},
      '{CMD_DIVU,   1'b1, 64'hffff_fffe, 64'd1, 1'b1, '{64'hffff_ffff_ffff_fffe, ST_OK}},
      '{CMD_AND,    1'b0, ONES64, 64'h0f0f, 1'b1, '{64'h0f0f, ST_OK}},
      '{CMD_UNKNOWN,1'b0, ONES64, ONES64, 1'b1, '{64'd0, ST_UNSUP}}
   };

   // ---------------------------------------------------------------- sender
   function automatic logic [63:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return ONES64;
         2: return MIN64;
         3: return 64'(signed'($urandom_range(0, 20)) - 10);
         4: return {32'($urandom_range(0, 1) ? 32'hffff_ffff : 32'h0), $urandom};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // offer one beat; returns at the edge that takes it
   task automatic send_beat(cmd_type cmd, logic word, logic [63:0] a, logic [63:0] b,
                            outcome_type want);
      logic took;
      if (phase == PH_SEND_IDLE || phase == PH_BOTH) begin
         while ($urandom_range(0, 99) < ((phase == PH_BOTH) ? 19 : 76)) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd <= cmd;
      req_ch.word_mode <= word;
      req_ch.src_a <= a;
      req_ch.src_b <= b;
      do begin
         @(negedge clock);
         took = req_ch.ready;
         @(posedge clock);
      end while (!took);
      pending_results.push_back(want);
      n_sent++;
   endtask

   initial begin
      cmd_type     c;
      logic        w;
      logic [63:0] a, b;
      req_ch.valid <= 1'b0;
      req_ch.cmd <= CMD_ADD;
      req_ch.word_mode <= 1'b0;
      req_ch.src_a <= '0;
      req_ch.src_b <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_rows[i])
         send_beat(dir_rows[i].cmd, dir_rows[i].word, dir_rows[i].a, dir_rows[i].b,
                   dir_rows[i].typed ? dir_rows[i].want
                      : alu_outcome(dir_rows[i].cmd, dir_rows[i].word,
                                    dir_rows[i].a, dir_rows[i].b));
      for (int i = 0; i < N_RANDOM; i++) begin
         // phase change: drain the pipe first
         if (i % (N_RANDOM / 4) == 0 && i != 0) begin
            req_ch.valid <= 1'b0;
            wait (pending_results.size() == 0);
            @(posedge clock);
            phase = phase_type'((int'(phase) + 1) % 4);
         end
         c = ($urandom_range(0, 15) == 0) ? cmd_type'($urandom_range(18, 31))
                                           : cmd_type'($urandom_range(0, 17));
         w = $urandom_range(0, 1);
         a = pick_operand();
         b = pick_operand();
         send_beat(c, w, a, b, alu_outcome(c, w, a, b));
      end
      req_ch.valid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (80) @(posedge clock);
      if (n_errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // ---------------------------------------------------------------- receiver
   // one long hold-off in the free phase so the pipe fills and backs up
   initial begin
      bit held;
      held = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held && n_sent >= 120) begin
            held = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         case (phase)
            PH_RECV_STALL: rsp_ch.ready <= ($urandom_range(0, 99) >= 76);
            PH_BOTH:       rsp_ch.ready <= ($urandom_range(0, 99) >= 19);
            default:       rsp_ch.ready <= 1'b1;
         endcase
      end
   end

   // response check, sampled mid-cycle where everything is settled
   always @(negedge clock) begin
      outcome_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            n_errors++;
            $display("%0t: unexpected beat result=%h status=%0d", $realtime,
                     rsp_ch.result, rsp_ch.status);
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.result !== want.result) begin
               n_errors++;
               $display("%0t: result expected %h actual %h", $realtime,
                        want.result, rsp_ch.result);
            end
            if (rsp_ch.status !== want.status) begin
               n_errors++;
               $display("%0t: status expected %0d actual %0d", $realtime,
                        want.status, rsp_ch.status);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end
endmodule
`default_nettype wire

/* sim.f */
+incdir+hw/rtl
hw/rtl/rvalu_pkg.sv
hw/rtl/rvalu_if.sv
hw/rtl/rv64im_integer_alu_core.sv
tb/testbench.sv
